[rtl/psd_pkg.sv]
// ----------------------------------------------------------------------------
// psd_pkg
// Shared constants and types of the point to segment squared distance block.
// ----------------------------------------------------------------------------
package psd_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int DIST_BITS      = 36;
    localparam int CFG_IDX_BITS   = 2;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_END_A_X = 2'd0,
        REG_END_A_Y = 2'd1,
        REG_END_B_X = 2'd2,
        REG_END_B_Y = 2'd3
    } cfg_reg_t;

endpackage

[rtl/psd_div.sv]
// ----------------------------------------------------------------------------
// psd_div
// Pipelined restoring divider: one quotient bit per stage, one word per cycle
// if en. The quotient must fit in QUO_BITS bits; a side word travels along.
// ----------------------------------------------------------------------------
module psd_div #(
    parameter int NUM_BITS  = 68,
    parameter int DEN_BITS  = 34,
    parameter int QUO_BITS  = 34,
    parameter int SIDE_BITS = 35
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [NUM_BITS-1:0]  num,
    input  logic [DEN_BITS-1:0]  den,
    input  logic [SIDE_BITS-1:0] side,
    output logic                 out_valid,
    output logic [QUO_BITS-1:0]  quo,
    output logic [SIDE_BITS-1:0] out_side
);

    localparam int LS = QUO_BITS + 1;

    logic                 v_reg    [LS];
    logic [DEN_BITS-1:0]  rem_reg  [LS];
    logic [DEN_BITS-1:0]  den_reg  [LS];
    logic [QUO_BITS-1:0]  low_reg  [LS];
    logic [SIDE_BITS-1:0] side_reg [LS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg[0] <= 1'b0;
        end else if (en) begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= DEN_BITS'(num >> QUO_BITS);
            low_reg[0]  <= num[QUO_BITS-1:0];
            den_reg[0]  <= den;
            side_reg[0] <= side;
        end
    end

    for (genvar k = 0; k < QUO_BITS; k++) begin : g_stage
        logic [DEN_BITS:0]   rem2;
        logic [DEN_BITS:0]   diff;
        logic                ge;
        logic [DEN_BITS-1:0] rem_next;
        logic [QUO_BITS-1:0] low_next;

        always_comb begin
            rem2     = {rem_reg[k], low_reg[k][QUO_BITS-1]};
            diff     = rem2 - {1'b0, den_reg[k]};
            ge       = (rem2 >= {1'b0, den_reg[k]});
            rem_next = ge ? diff[DEN_BITS-1:0] : rem2[DEN_BITS-1:0];
            low_next = {low_reg[k][QUO_BITS-2:0], ge};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k+1] <= 1'b0;
            end else if (en) begin
                v_reg[k+1] <= v_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k+1]  <= rem_next;
                low_reg[k+1]  <= low_next;
                den_reg[k+1]  <= den_reg[k];
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    assign out_valid = v_reg[QUO_BITS];
    assign quo       = low_reg[QUO_BITS];
    assign out_side  = side_reg[QUO_BITS];

endmodule

[rtl/point_segment_distance_sq_top.sv]
// ----------------------------------------------------------------------------
// point_segment_distance_sq_top
// Squared distance from streamed points to a segment held in registers.
// ----------------------------------------------------------------------------
// Usage:
//   cfg channel: write endpoint registers (index 0..3 = A.x, A.y, B.x, B.y)
//   while no point is in flight; cfg_ready is always high.
//   s channel: s_point_x/s_point_y, one point per cycle while s_ready is high.
//   m channel: one result word per point, in order: m_dist_sq and
//   m_foot_inside (1 when the perpendicular foot lies on the segment).
// Pipeline: from accept to m_valid a point passes through five arithmetic
//   stages, the divider input stage, one stage per quotient bit of the
//   pipelined divider, and the output register.
// Throughput: one word per cycle unless stalled; the divider sets the depth.
// Stall: while m_valid is high and m_ready low the whole pipeline holds and
//   s_ready drops; nothing is lost or repeated.
// Reset: aresetn low clears all valid bits and sets the endpoints to zero.
// ----------------------------------------------------------------------------
module point_segment_distance_sq_top #(
    parameter int COORD_BITS = psd_pkg::COORD_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [psd_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [COORD_BITS-1:0]              cfg_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [COORD_BITS-1:0]       s_point_x,
    input  logic signed [COORD_BITS-1:0]       s_point_y,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [psd_pkg::DIST_BITS-1:0]      m_dist_sq,
    output logic                               m_foot_inside
);

    import psd_pkg::*;

    localparam int DB = COORD_BITS + 1;
    localparam int PB = 2 * COORD_BITS + 2;
    localparam int SB = PB + 1;
    localparam int CW = PB;
    localparam int H  = (CW + 1) / 2;
    localparam int HW = CW - H;
    localparam int NW = 2 * CW;
    localparam int RW = (PB > DIST_BITS) ? PB : DIST_BITS;

    logic en;

    logic signed [COORD_BITS-1:0] ax_reg, ay_reg, bx_reg, by_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ax_reg <= '0;
            ay_reg <= '0;
            bx_reg <= '0;
            by_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                REG_END_A_X: ax_reg <= cfg_data;
                REG_END_A_Y: ay_reg <= cfg_data;
                REG_END_B_X: bx_reg <= cfg_data;
                REG_END_B_Y: by_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // stage 1: differences
    logic                 v1_reg;
    logic signed [DB-1:0] dx_reg, dy_reg, wx_reg, wy_reg, vx_reg, vy_reg;

    // stage 2: products
    logic                 v2_reg;
    logic signed [PB-1:0] pdd_reg, pee_reg, ptx_reg, pty_reg, pc1_reg, pc2_reg;
    logic signed [PB-1:0] pwx_reg, pwy_reg, pvx_reg, pvy_reg;

    // stage 3: sums
    logic                 v3_reg;
    logic signed [SB-1:0] len2_reg, t_reg, cross_reg, da_reg, db_reg;

    // stage 4: case decision
    logic                 v4_reg, in4_reg;
    logic [CW-1:0]        mag_reg;
    logic [PB-1:0]        den4_reg, dmin4_reg;

    // stage 5: partial products of the square
    logic                 v5_reg, in5_reg;
    logic [2*H-1:0]       pll_reg;
    logic [CW-1:0]        plh_reg;
    logic [2*HW-1:0]      phh_reg;
    logic [PB-1:0]        den5_reg, dmin5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    logic signed [SB-1:0] mag_s;
    logic                 in4_next;
    logic [PB-1:0]        dmin4_next;

    always_comb begin
        in4_next   = (len2_reg != '0) && (t_reg >= 0) && (t_reg <= len2_reg);
        mag_s      = (cross_reg < 0) ? -cross_reg : cross_reg;
        dmin4_next = (da_reg < db_reg) ? PB'(da_reg) : PB'(db_reg);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dx_reg    <= DB'(bx_reg) - DB'(ax_reg);
            dy_reg    <= DB'(by_reg) - DB'(ay_reg);
            wx_reg    <= DB'(s_point_x) - DB'(ax_reg);
            wy_reg    <= DB'(s_point_y) - DB'(ay_reg);
            vx_reg    <= DB'(s_point_x) - DB'(bx_reg);
            vy_reg    <= DB'(s_point_y) - DB'(by_reg);

            pdd_reg   <= PB'(dx_reg) * PB'(dx_reg);
            pee_reg   <= PB'(dy_reg) * PB'(dy_reg);
            ptx_reg   <= PB'(wx_reg) * PB'(dx_reg);
            pty_reg   <= PB'(wy_reg) * PB'(dy_reg);
            pc1_reg   <= PB'(dx_reg) * PB'(wy_reg);
            pc2_reg   <= PB'(dy_reg) * PB'(wx_reg);
            pwx_reg   <= PB'(wx_reg) * PB'(wx_reg);
            pwy_reg   <= PB'(wy_reg) * PB'(wy_reg);
            pvx_reg   <= PB'(vx_reg) * PB'(vx_reg);
            pvy_reg   <= PB'(vy_reg) * PB'(vy_reg);

            len2_reg  <= SB'(pdd_reg) + SB'(pee_reg);
            t_reg     <= SB'(ptx_reg) + SB'(pty_reg);
            cross_reg <= SB'(pc1_reg) - SB'(pc2_reg);
            da_reg    <= SB'(pwx_reg) + SB'(pwy_reg);
            db_reg    <= SB'(pvx_reg) + SB'(pvy_reg);

            in4_reg   <= in4_next;
            mag_reg   <= mag_s[CW-1:0];
            den4_reg  <= len2_reg[PB-1:0];
            dmin4_reg <= dmin4_next;

            in5_reg   <= in4_reg;
            pll_reg   <= (2*H)'(mag_reg[H-1:0]) * (2*H)'(mag_reg[H-1:0]);
            plh_reg   <= CW'(mag_reg[CW-1:H]) * CW'(mag_reg[H-1:0]);
            phh_reg   <= (2*HW)'(mag_reg[CW-1:H]) * (2*HW)'(mag_reg[CW-1:H]);
            den5_reg  <= den4_reg;
            dmin5_reg <= dmin4_reg;
        end
    end

    // stage 6 feeds the divider: assemble the square
    logic [NW-1:0] num_next;

    assign num_next = (NW'(phh_reg) << (2*H)) + (NW'(plh_reg) << (H + 1)) + NW'(pll_reg);

    logic          dv_valid;
    logic [PB-1:0] dv_quo;
    logic [PB:0]   dv_side;

    psd_div #(
        .NUM_BITS  (NW),
        .DEN_BITS  (PB),
        .QUO_BITS  (PB),
        .SIDE_BITS (PB + 1)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v5_reg),
        .num       (num_next),
        .den       (den5_reg),
        .side      ({in5_reg, dmin5_reg}),
        .out_valid (dv_valid),
        .quo       (dv_quo),
        .out_side  (dv_side)
    );

    logic                 m_valid_reg, m_inside_reg;
    logic [DIST_BITS-1:0] m_dist_reg;
    logic [RW-1:0]        res_w;
    logic [DIST_BITS-1:0] dist_next;

    always_comb begin
        res_w     = dv_side[PB] ? RW'(dv_quo) : RW'(dv_side[PB-1:0]);
        dist_next = (res_w > RW'({DIST_BITS{1'b1}})) ? {DIST_BITS{1'b1}}
                                                      : res_w[DIST_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_dist_reg   <= dist_next;
            m_inside_reg <= dv_side[PB];
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_dist_sq     = m_dist_reg;
    assign m_foot_inside = m_inside_reg;

`ifndef SYNTHESIS
    a_inside_nonzero_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_foot_inside) |-> (ax_reg != bx_reg || ay_reg != by_reg))
        else $error("foot inside reported for a zero-length segment");

    a_perp_not_above_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (dv_valid && dv_side[PB]) |-> (dv_quo <= dv_side[PB-1:0]))
        else $error("perpendicular distance exceeds nearest endpoint distance");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_stall_holds_pipe: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(dv_valid) && $stable(dv_quo))
        else $error("divider advanced during stall");
`endif

endmodule
